>>> hdl/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg: shared types and constants of the binary min-heap
// Key and index widths, operation and status codes, and the transfer structs
// of the command and result channels.
// ----------------------------------------------------------------------------
package bmh_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;

  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_DEC    = 2'd2;
  localparam logic [1:0] KIND_DEL    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [KEY_W-1:0] key_value;
    logic [IDX_W-1:0]        entry_index;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] popped_key;
    logic [1:0]              status;
    logic signed [KEY_W-1:0] min_key;
    logic [CNT_W-1:0]        entry_count;
  } out_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] wa;
    logic [IDX_W-1:0] ra;
    logic [IDX_W-1:0] rb;
  } store_ctl_t;

endpackage

>>> hdl/bmh_store.sv
// ----------------------------------------------------------------------------
// bmh_store: heap key store
// One write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module bmh_store (
  input  logic                           clk,
  input  bmh_pkg::store_ctl_t            ctl,
  input  logic signed [bmh_pkg::KEY_W-1:0] wdata,
  output logic signed [bmh_pkg::KEY_W-1:0] rdata_a,
  output logic signed [bmh_pkg::KEY_W-1:0] rdata_b
);

  logic signed [bmh_pkg::KEY_W-1:0] mem [bmh_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.wa] <= wdata;
    end
    rdata_a <= mem[ctl.ra];
    rdata_b <= mem[ctl.rb];
  end

endmodule

>>> hdl/binary_min_heap.sv
// ----------------------------------------------------------------------------
// binary_min_heap: priority queue of signed keys held as an array heap
// A command is taken when start is high and busy low. Busy stays high until
// the single result is ready; the result is shown on out_data under out_valid
// for one cycle, the first cycle with busy low, and the receiver must take it
// as it comes. The key store has one write and two registered read ports, so
// each heap level takes a read state and a compare state. A refused command
// goes straight to the result state; insert and decrease climb from their slot
// toward the root and then write the key; a pop that empties the heap goes
// straight to the result, otherwise the last entry is read and sunk from the
// root; a delete reads its entry, climbs with the least key and then pops.
// ----------------------------------------------------------------------------
module binary_min_heap (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bmh_pkg::in_t  in_data,
  output logic          out_valid,
  output bmh_pkg::out_t out_data
);

  localparam int KW = bmh_pkg::KEY_W;
  localparam int IW = bmh_pkg::IDX_W;
  localparam int CW = bmh_pkg::CNT_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DELRD   = 4'd1;
  localparam logic [3:0] S_UP      = 4'd2;
  localparam logic [3:0] S_UPCMP   = 4'd3;
  localparam logic [3:0] S_UPEND   = 4'd4;
  localparam logic [3:0] S_POP     = 4'd5;
  localparam logic [3:0] S_POPRD   = 4'd6;
  localparam logic [3:0] S_DOWN    = 4'd7;
  localparam logic [3:0] S_DOWNCMP = 4'd8;
  localparam logic [3:0] S_RESP    = 4'd9;

  localparam logic [CW-1:0] CNT_FULL = CW'(bmh_pkg::CAPACITY);

  logic [3:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [IW-1:0]        pos_r, pos_nxt;
  logic signed [KW-1:0] cur_r, cur_nxt;
  logic signed [KW-1:0] root_r, root_nxt;
  logic signed [KW-1:0] popped_r, popped_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 del_r, del_nxt;
  logic                 out_valid_r, out_valid_nxt;
  bmh_pkg::out_t        out_r, out_nxt;

  bmh_pkg::store_ctl_t  ctl;
  logic signed [KW-1:0] wdata, rdata_a, rdata_b;

  logic [IW-1:0]        pos_m1, parent;
  logic [CW-1:0]        lchild, count_m1;
  logic [CW:0]          rchild;
  logic                 l_ok, r_ok;
  logic signed [KW-1:0] best_val;
  logic [IW-1:0]        best_idx;

  bmh_store u_store (
    .clk     (clk),
    .ctl     (ctl),
    .wdata   (wdata),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign pos_m1   = pos_r - IW'(1);
  assign parent   = {1'b0, pos_m1[IW-1:1]};
  assign lchild   = {pos_r, 1'b1};
  assign rchild   = {1'b0, pos_r, 1'b0} + (CW+1)'(2);
  assign count_m1 = count_r - CW'(1);
  assign l_ok     = lchild < count_r;
  assign r_ok     = rchild < {1'b0, count_r};

  always_comb begin
    best_val = cur_r;
    best_idx = pos_r;
    if (l_ok && (rdata_a < best_val)) begin
      best_val = rdata_a;
      best_idx = lchild[IW-1:0];
    end
    if (r_ok && (rdata_b < best_val)) begin
      best_val = rdata_b;
      best_idx = rchild[IW-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    del_nxt       = del_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ctl.we        = 1'b0;
    ctl.wa        = pos_r;
    ctl.ra        = pos_r;
    ctl.rb        = pos_r;
    wdata         = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt = bmh_pkg::ST_OK;
          popped_nxt = '0;
          del_nxt    = 1'b0;
          unique case (in_data.kind)
            bmh_pkg::KIND_INSERT: begin
              if (count_r == CNT_FULL) begin
                status_nxt = bmh_pkg::ST_FULL;
                state_nxt  = S_RESP;
              end else begin
                pos_nxt   = count_r[IW-1:0];
                cur_nxt   = in_data.key_value;
                count_nxt = count_r + CW'(1);
                state_nxt = S_UP;
              end
            end
            bmh_pkg::KIND_POP: begin
              if (count_r == '0) begin
                status_nxt = bmh_pkg::ST_EMPTY;
                popped_nxt = bmh_pkg::KEY_MAX;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_POP;
              end
            end
            bmh_pkg::KIND_DEC: begin
              if ({1'b0, in_data.entry_index} >= count_r) begin
                status_nxt = bmh_pkg::ST_RANGE;
                state_nxt  = S_RESP;
              end else begin
                pos_nxt   = in_data.entry_index;
                cur_nxt   = in_data.key_value;
                state_nxt = S_UP;
              end
            end
            bmh_pkg::KIND_DEL: begin
              if ({1'b0, in_data.entry_index} >= count_r) begin
                status_nxt = bmh_pkg::ST_RANGE;
                state_nxt  = S_RESP;
              end else begin
                ctl.ra    = in_data.entry_index;
                pos_nxt   = in_data.entry_index;
                cur_nxt   = bmh_pkg::KEY_MIN;
                del_nxt   = 1'b1;
                state_nxt = S_DELRD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DELRD: begin
        popped_nxt = rdata_a;
        state_nxt  = S_UP;
      end
      S_UP: begin
        if (pos_r == '0) begin
          state_nxt = S_UPEND;
        end else begin
          ctl.ra    = parent;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (rdata_a <= cur_r) begin
          state_nxt = S_UPEND;
        end else begin
          ctl.we    = 1'b1;
          wdata     = rdata_a;
          pos_nxt   = parent;
          state_nxt = S_UP;
        end
      end
      S_UPEND: begin
        ctl.we    = 1'b1;
        state_nxt = del_r ? S_POP : S_RESP;
      end
      S_POP: begin
        if (!del_r) begin
          popped_nxt = root_r;
        end
        count_nxt = count_m1;
        if (count_m1 == '0) begin
          state_nxt = S_RESP;
        end else begin
          ctl.ra    = count_m1[IW-1:0];
          state_nxt = S_POPRD;
        end
      end
      S_POPRD: begin
        cur_nxt   = rdata_a;
        pos_nxt   = '0;
        state_nxt = S_DOWN;
      end
      S_DOWN: begin
        if (!l_ok) begin
          ctl.we    = 1'b1;
          state_nxt = S_RESP;
        end else begin
          ctl.ra    = lchild[IW-1:0];
          ctl.rb    = rchild[IW-1:0];
          state_nxt = S_DOWNCMP;
        end
      end
      S_DOWNCMP: begin
        ctl.we = 1'b1;
        if (best_idx == pos_r) begin
          state_nxt = S_RESP;
        end else begin
          wdata     = best_val;
          pos_nxt   = best_idx;
          state_nxt = S_DOWN;
        end
      end
      S_RESP: begin
        out_valid_nxt       = 1'b1;
        out_nxt.popped_key  = popped_r;
        out_nxt.status      = status_r;
        out_nxt.min_key     = (count_r == '0) ? bmh_pkg::KEY_MAX : root_r;
        out_nxt.entry_count = count_r;
        state_nxt           = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign root_nxt = (ctl.we && (ctl.wa == '0)) ? wdata : root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      del_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      del_r       <= del_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cur_r    <= cur_nxt;
    root_r   <= root_nxt;
    popped_r <= popped_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("command transfer did not raise busy");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.entry_count <= CNT_FULL)
    else $error("entry count beyond capacity");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.entry_count == '0) |-> out_data.min_key == bmh_pkg::KEY_MAX)
    else $error("empty heap reports a minimum other than the largest key");

endmodule
